// File: design/fjos_pkg.sv
// Shared definitions for the flat JSON object scanner: limits, field widths,
// character codes, record layout and the keyword tables.
// Used by fjos_step, fjos_fifo and flat_json_object_scanner.
package fjos_pkg;

	localparam int MAX_PAIRS = 16;
	localparam int MAX_BYTES = 4096;
	localparam int MAX_DEPTH = 15;

	localparam int POS_W   = $clog2(MAX_BYTES + 1);
	localparam int PAIRS_W = $clog2(MAX_PAIRS + 1);
	localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);

	localparam int IDX_W  = 4;
	localparam int OFS_W  = 12;
	localparam int LEN_W  = 13;
	localparam int TYPE_W = 3;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 64;

	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;

	localparam logic [TYPE_W-1:0] VT_STRING = 3'd0;
	localparam logic [TYPE_W-1:0] VT_NUMBER = 3'd1;
	localparam logic [TYPE_W-1:0] VT_OBJECT = 3'd2;
	localparam logic [TYPE_W-1:0] VT_BOOL   = 3'd3;
	localparam logic [TYPE_W-1:0] VT_NULL   = 3'd4;

	localparam logic REC_PAIR   = 1'b0;
	localparam logic REC_STATUS = 1'b1;
	localparam logic ST_OK      = 1'b0;
	localparam logic ST_ERROR   = 1'b1;

	localparam logic [1:0] LIT_TRUE  = 2'd0;
	localparam logic [1:0] LIT_FALSE = 2'd1;
	localparam logic [1:0] LIT_NULL  = 2'd2;

	typedef struct packed {
		logic              kind;
		logic [IDX_W-1:0]  pair_index;
		logic [OFS_W-1:0]  key_offset;
		logic [LEN_W-1:0]  key_length;
		logic [OFS_W-1:0]  value_offset;
		logic [LEN_W-1:0]  value_length;
		logic [TYPE_W-1:0] value_type;
		logic              status;
		logic              final_of_run;
	} rec_t;

	// Results of one byte: up to two records, the first always used first.
	typedef struct packed {
		logic [1:0] cnt;
		rec_t       a;
		rec_t       b;
	} push_t;

	function automatic logic [2:0] lit_len(input logic [1:0] kind);
		logic [2:0] len;
		case (kind)
			LIT_FALSE: len = 3'd5;
			default:   len = 3'd4;
		endcase
		return len;
	endfunction

	function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] idx);
		logic [7:0] ch;
		ch = 8'h00;
		case (kind)
			LIT_FALSE: begin
				case (idx)
					3'd0:    ch = 8'h66;
					3'd1:    ch = 8'h61;
					3'd2:    ch = 8'h6C;
					3'd3:    ch = 8'h73;
					3'd4:    ch = 8'h65;
					default: ch = 8'h00;
				endcase
			end
			LIT_NULL: begin
				case (idx)
					3'd0:    ch = 8'h6E;
					3'd1:    ch = 8'h75;
					3'd2:    ch = 8'h6C;
					3'd3:    ch = 8'h6C;
					default: ch = 8'h00;
				endcase
			end
			default: begin
				case (idx)
					3'd0:    ch = 8'h74;
					3'd1:    ch = 8'h72;
					3'd2:    ch = 8'h75;
					3'd3:    ch = 8'h65;
					default: ch = 8'h00;
				endcase
			end
		endcase
		return ch;
	endfunction

endpackage

// File: design/fjos_step.sv
// Scanner state machine: takes one registered byte per enable and returns
// the pair and status records that byte produces. Depends on fjos_pkg.
module fjos_step (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic [7:0]    data,
	input  logic          last,
	output fjos_pkg::push_t push
);
	import fjos_pkg::*;

	typedef enum logic [3:0] {
		PH_OPEN, PH_FIRST, PH_KEYSTART, PH_KEY, PH_COLON, PH_VALSTART,
		PH_VSTR, PH_NESTED, PH_NESTSTR, PH_LIT, PH_NUM, PH_AFTER
	} phase_t;

	phase_t             phase_q, phase_d;
	logic [POS_W-1:0]   pos_q, pos_d;
	logic [PAIRS_W-1:0] pairs_q, pairs_d;
	logic [DEPTH_W-1:0] depth_q, depth_d;
	logic               esc_q, esc_d;
	logic [1:0]         lkind_q, lkind_d;
	logic [2:0]         lpos_q, lpos_d;
	logic               digit_q, digit_d;
	logic [OFS_W-1:0]   hko_q, hko_d;
	logic [LEN_W-1:0]   hkl_q, hkl_d;
	logic [OFS_W-1:0]   hvo_q, hvo_d;
	logic               fin_q, fin_d;

	logic             ws, is_dig, after, pair_v, stat_v, stat_err;
	logic [LEN_W-1:0] pair_len;
	logic [TYPE_W-1:0] pair_type;
	logic [OFS_W-1:0] pair_vo;
	logic [POS_W-1:0] pos_inc;
	logic [1:0]       k;
	logic [2:0]       llen, lpos_inc;
	rec_t             pr, sr;

	assign ws      = (data == CH_SPACE) || (data == CH_TAB) || (data == CH_LF) || (data == CH_CR);
	assign is_dig  = (data >= CH_ZERO) && (data <= CH_NINE);
	assign pos_inc = pos_q + 1'b1;
	assign k       = (lkind_q == LIT_FALSE || lkind_q == LIT_NULL) ? lkind_q : LIT_TRUE;
	assign llen    = lit_len(k);
	assign lpos_inc = lpos_q + 1'b1;

	always_comb begin
		phase_d   = phase_q;
		pos_d     = pos_q;
		pairs_d   = pairs_q;
		depth_d   = depth_q;
		esc_d     = esc_q;
		lkind_d   = lkind_q;
		lpos_d    = lpos_q;
		digit_d   = digit_q;
		hko_d     = hko_q;
		hkl_d     = hkl_q;
		hvo_d     = hvo_q;
		fin_d     = fin_q;
		after     = 1'b0;
		pair_v    = 1'b0;
		stat_v    = 1'b0;
		stat_err  = ST_OK;
		pair_len  = '0;
		pair_type = VT_STRING;
		pair_vo   = hvo_q;

		if (en && !fin_q) begin
			if (pos_q >= POS_W'(MAX_BYTES)) begin
				stat_v   = 1'b1;
				stat_err = ST_ERROR;
			end else begin
				pos_d = pos_inc;
				case (phase_q)
					PH_OPEN: begin
						if (!ws) begin
							if (data == CH_LBRACE) phase_d = PH_FIRST;
							else begin
								stat_v   = 1'b1;
								stat_err = ST_ERROR;
							end
						end
					end
					PH_FIRST, PH_KEYSTART: begin
						if (!ws) begin
							if (data == CH_RBRACE && phase_q == PH_FIRST) begin
								stat_v = 1'b1;
							end else if (data == CH_QUOTE) begin
								hko_d   = pos_inc[OFS_W-1:0];
								esc_d   = 1'b0;
								phase_d = PH_KEY;
							end else begin
								stat_v   = 1'b1;
								stat_err = ST_ERROR;
							end
						end
					end
					PH_KEY: begin
						if (esc_q) esc_d = 1'b0;
						else if (data == CH_BSLASH) esc_d = 1'b1;
						else if (data == CH_QUOTE) begin
							hkl_d   = pos_q - {1'b0, hko_q};
							phase_d = PH_COLON;
						end
					end
					PH_COLON: begin
						if (!ws) begin
							if (data == CH_COLON) phase_d = PH_VALSTART;
							else begin
								stat_v   = 1'b1;
								stat_err = ST_ERROR;
							end
						end
					end
					PH_VALSTART: begin
						if (!ws) begin
							hvo_d = pos_q[OFS_W-1:0];
							if (data == CH_QUOTE) begin
								hvo_d   = pos_inc[OFS_W-1:0];
								esc_d   = 1'b0;
								phase_d = PH_VSTR;
							end else if (data == CH_LBRACE) begin
								depth_d = DEPTH_W'(1);
								phase_d = PH_NESTED;
							end else if (data == CH_T || data == CH_F || data == CH_N) begin
								lkind_d = (data == CH_T) ? LIT_TRUE :
								          (data == CH_F) ? LIT_FALSE : LIT_NULL;
								lpos_d  = 3'd1;
								phase_d = PH_LIT;
							end else if (data == CH_PLUS || data == CH_MINUS) begin
								digit_d = 1'b0;
								phase_d = PH_NUM;
							end else if (is_dig) begin
								digit_d = 1'b1;
								phase_d = PH_NUM;
							end else begin
								stat_v   = 1'b1;
								stat_err = ST_ERROR;
							end
						end
					end
					PH_VSTR: begin
						if (esc_q) esc_d = 1'b0;
						else if (data == CH_BSLASH) esc_d = 1'b1;
						else if (data == CH_QUOTE) begin
							pair_v    = 1'b1;
							pair_len  = pos_q - {1'b0, hvo_q};
							pair_type = VT_STRING;
						end
					end
					PH_NESTED: begin
						if (data == CH_QUOTE) begin
							esc_d   = 1'b0;
							phase_d = PH_NESTSTR;
						end else if (data == CH_LBRACE) begin
							if (depth_q >= DEPTH_W'(MAX_DEPTH)) begin
								stat_v   = 1'b1;
								stat_err = ST_ERROR;
							end else begin
								depth_d = depth_q + 1'b1;
							end
						end else if (data == CH_RBRACE) begin
							depth_d = depth_q - 1'b1;
							if (depth_q == DEPTH_W'(1)) begin
								pair_v    = 1'b1;
								pair_len  = pos_inc - {1'b0, hvo_q};
								pair_type = VT_OBJECT;
							end
						end
					end
					PH_NESTSTR: begin
						if (esc_q) esc_d = 1'b0;
						else if (data == CH_BSLASH) esc_d = 1'b1;
						else if (data == CH_QUOTE) phase_d = PH_NESTED;
					end
					PH_LIT: begin
						if (lpos_q >= llen || data != lit_char(k, lpos_q)) begin
							stat_v   = 1'b1;
							stat_err = ST_ERROR;
						end else begin
							lpos_d = lpos_inc;
							if (lpos_inc == llen) begin
								pair_v    = 1'b1;
								pair_len  = LEN_W'(llen);
								pair_type = (k == LIT_NULL) ? VT_NULL : VT_BOOL;
							end
						end
					end
					PH_NUM: begin
						if (is_dig) digit_d = 1'b1;
						else if (!digit_q) begin
							stat_v   = 1'b1;
							stat_err = ST_ERROR;
						end else begin
							// The terminating byte is handled again as the byte after the value.
							pair_v    = 1'b1;
							pair_len  = pos_q - {1'b0, hvo_q};
							pair_type = VT_NUMBER;
							after     = 1'b1;
						end
					end
					PH_AFTER: after = 1'b1;
					default: begin
						stat_v   = 1'b1;
						stat_err = ST_ERROR;
					end
				endcase

				if (pair_v) begin
					pairs_d = pairs_q + 1'b1;
					phase_d = PH_AFTER;
				end

				if (after && !ws) begin
					if (data == CH_COMMA) begin
						if (pairs_d >= PAIRS_W'(MAX_PAIRS)) begin
							stat_v   = 1'b1;
							stat_err = ST_ERROR;
						end else begin
							phase_d = PH_KEYSTART;
						end
					end else if (data == CH_RBRACE) begin
						stat_v = 1'b1;
					end else begin
						stat_v   = 1'b1;
						stat_err = ST_ERROR;
					end
				end

				// Buffer ended with the object still open; a pending number is closed first.
				// The number may have started on this very byte, so its offset is the new one.
				if (last && !stat_v) begin
					if (phase_d == PH_NUM && digit_d) begin
						pair_v    = 1'b1;
						pair_vo   = hvo_d;
						pair_len  = pos_inc - {1'b0, hvo_d};
						pair_type = VT_NUMBER;
					end
					stat_v   = 1'b1;
					stat_err = ST_ERROR;
				end
			end
			if (stat_v) fin_d = 1'b1;
		end

		if (en && last) begin
			phase_d = PH_OPEN;
			pos_d   = '0;
			pairs_d = '0;
			depth_d = '0;
			esc_d   = 1'b0;
			lkind_d = '0;
			lpos_d  = '0;
			digit_d = 1'b0;
			hko_d   = '0;
			hkl_d   = '0;
			hvo_d   = '0;
			fin_d   = 1'b0;
		end
	end

	always_comb begin
		pr              = '0;
		pr.kind         = REC_PAIR;
		pr.pair_index   = pairs_q[IDX_W-1:0];
		pr.key_offset   = hko_q;
		pr.key_length   = hkl_q;
		pr.value_offset = pair_vo;
		pr.value_length = pair_len;
		pr.value_type   = pair_type;
		pr.status       = ST_OK;
		pr.final_of_run = !stat_v;

		sr              = '0;
		sr.kind         = REC_STATUS;
		sr.status       = stat_err;
		sr.final_of_run = 1'b1;

		push.cnt = {1'b0, pair_v} + {1'b0, stat_v};
		push.a   = pair_v ? pr : sr;
		push.b   = sr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_OPEN;
			pos_q   <= '0;
			pairs_q <= '0;
			depth_q <= '0;
			esc_q   <= 1'b0;
			lkind_q <= '0;
			lpos_q  <= '0;
			digit_q <= 1'b0;
			hko_q   <= '0;
			hkl_q   <= '0;
			hvo_q   <= '0;
			fin_q   <= 1'b0;
		end else begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			pairs_q <= pairs_d;
			depth_q <= depth_d;
			esc_q   <= esc_d;
			lkind_q <= lkind_d;
			lpos_q  <= lpos_d;
			digit_q <= digit_d;
			hko_q   <= hko_d;
			hkl_q   <= hkl_d;
			hvo_q   <= hvo_d;
			fin_q   <= fin_d;
		end
	end

endmodule

// File: design/fjos_fifo.sv
// Result queue of the scanner: takes up to two records per cycle and hands
// them out one at a time on the output request. Depends on fjos_pkg.
module fjos_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  fjos_pkg::push_t push,
	input  logic            pop,
	output fjos_pkg::rec_t  head,
	output logic            head_valid,
	output logic            room,
	output logic [fjos_pkg::FIFO_CW-1:0] level
);
	import fjos_pkg::*;

	rec_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q, rd_q, wr_next;
	logic [FIFO_CW-1:0] cnt_q;
	logic               do_pop;

	assign wr_next    = wr_q + 1'b1;
	assign head       = mem_q[rd_q];
	assign head_valid = (cnt_q != '0);
	assign do_pop     = pop && head_valid;
	// Room for the two records that the worst byte can produce.
	assign room       = (cnt_q <= FIFO_CW'(FIFO_DEPTH - 2));
	assign level      = cnt_q;

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) mem_q[wr_q] <= push.a;
		if (push.cnt == 2'd2) mem_q[wr_next] <= push.b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + FIFO_AW'(push.cnt);
			if (do_pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + FIFO_CW'(push.cnt) - FIFO_CW'(do_pop);
		end
	end

endmodule

// File: design/flat_json_object_scanner.sv
// Flat JSON object scanner. Bytes of a buffer arrive one per request on the
// slave side, tlast marking the final byte. A byte is taken into an input
// register and handled by the scanner state machine once the result queue has
// room; its records are written into that queue and reach the master side
// behind any records still waiting there. One byte is taken every
// cycle; the input side pauses only while the four-entry result queue holds
// more than two undelivered records, since one byte can produce two (a pair
// record and the status record). Each completed pair yields a pair record and
// every buffer ends in one status record (ok or error); bytes after the status
// produce nothing up to the byte marked last, after which the next buffer starts.
// Depends on fjos_pkg, fjos_step and fjos_fifo.
module flat_json_object_scanner (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	// [3:0] pair_index, [15:4] key_offset, [28:16] key_length, [40:29] value_offset,
	// [53:41] value_length, [56:54] value_type, [57] status, [63:58] zero
	output logic [fjos_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic        m_tuser,   // record_kind
	output logic        m_tlast    // final_of_run
);
	import fjos_pkg::*;

	logic               v_s1;
	logic [7:0]         byte_s1;
	logic               last_s1;
	logic               room, en, head_valid;
	logic [FIFO_CW-1:0] level;
	push_t              push;
	rec_t               head;

	assign en       = v_s1 && room;
	assign s_tready = !v_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			v_s1 <= 1'b1;
		end else if (en) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	fjos_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.data   (byte_s1),
		.last   (last_s1),
		.push   (push)
	);

	fjos_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pop        (m_tready),
		.head       (head),
		.head_valid (head_valid),
		.room       (room),
		.level      (level)
	);

	assign m_tvalid = head_valid;
	assign m_tuser  = head.kind;
	assign m_tlast  = head.final_of_run;
	assign m_tdata  = {6'd0, head.status, head.value_type, head.value_length,
	                   head.value_offset, head.key_length, head.key_offset,
	                   head.pair_index};

`ifndef ASSERT_OFF
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level <= FIFO_CW'(FIFO_DEPTH))
		else $error("result queue overfilled");

	a_two_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.cnt == 2'd2 |-> (push.a.kind == REC_PAIR && push.b.kind == REC_STATUS))
		else $error("two records from one byte must be pair then status");

	a_status_final: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("status record not marked final");

	a_no_push_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!en |-> push.cnt == 2'd0)
		else $error("records produced without a byte");
`endif

endmodule
